### hw/rtl/sktt_pkg.sv
// Shared types, constants and codes for the sorted key table with deleted marks.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sktt_pkg;

    // Storage dimensions of the table.
    localparam int TABLE_DEPTH  = 256;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;

    // Index into the cell row and fill count widths.
    localparam int IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Fixed port field widths.
    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 8;
    localparam int COUNT_W   = 9;

    // Read multiplexer: groups of sixteen cells, then a choice between groups.
    localparam int RD_GRP    = 16;
    localparam int RD_GRP_W  = 4;
    localparam int RD_NGRP   = (TABLE_DEPTH + RD_GRP - 1) / RD_GRP;
    localparam int RD_NGRP_W = (RD_NGRP > 1) ? $clog2(RD_NGRP) : 1;
    localparam int RD_SEL_W  = RD_GRP_W + RD_NGRP_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TRIM   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_KEY   = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    mark;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_CAPTURE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_MARK    = 3'd3,
        OP_SWAP    = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/sktt_cell.sv
// One cell of the table row: holds one entry and trades it with its neighbours.
// Depends on sktt_pkg.
`default_nettype none

module sktt_cell (
    input  wire logic                       i_clk,
    input  wire sktt_pkg::t_cell_ctl        i_ctl,
    input  wire sktt_pkg::t_entry           i_new,
    input  wire logic [sktt_pkg::CNT_W-1:0] i_count,
    input  wire logic [sktt_pkg::IDX_W-1:0] i_pos,
    input  wire sktt_pkg::t_entry           i_below,
    input  wire logic                       i_below_lt,
    input  wire logic                       i_below_live,
    input  wire sktt_pkg::t_entry           i_above,
    input  wire logic                       i_above_live,
    output sktt_pkg::t_entry                o_entry,
    output logic                            o_lt,
    output logic                            o_eq,
    output logic                            o_live
);
    import sktt_pkg::*;

    t_entry r_entry;
    logic   r_lt;
    logic   r_eq;
    logic   occ;
    logic   lower;

    assign occ    = CNT_W'(i_pos) < i_count;
    assign o_live = occ && !r_entry.mark;
    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    // In a swap round this cell is the lower half of its pair when its parity matches.
    assign lower   = (i_pos[0] == i_ctl.phase);

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CAPTURE: begin
                r_lt <= occ && (r_entry.key < i_new.key);
                r_eq <= occ && (r_entry.key == i_new.key);
            end
            OP_INSERT: begin
                if (!i_below_lt) begin
                    r_entry <= i_below;
                end else if (!r_lt) begin
                    r_entry <= i_new;
                end
            end
            OP_MARK: begin
                if (r_eq && i_below_lt) begin
                    r_entry.mark <= 1'b1;
                end
            end
            OP_SWAP: begin
                if (lower) begin
                    if (!o_live && i_above_live) begin
                        r_entry <= i_above;
                    end
                end else if (!i_below_live && o_live) begin
                    r_entry <= i_below;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/sktt_search.sv
// Iterative lower-bound search over the registered key-below flags of the cell row.
// Depends on sktt_pkg.
`default_nettype none

module sktt_search (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire logic [sktt_pkg::CNT_W-1:0]       i_count,
    input  wire logic [sktt_pkg::TABLE_DEPTH-1:0] i_lt,
    output logic                                  o_done,
    output logic [sktt_pkg::CNT_W-1:0]            o_pos
);
    import sktt_pkg::*;

    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] mid;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign o_done = (r_lo == r_hi);
    assign o_pos  = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_load) begin
            r_lo <= '0;
            r_hi <= i_count;
        end else if (r_lo < r_hi) begin
            if (i_lt[mid[IDX_W-1:0]]) begin
                r_lo <= mid + CNT_W'(1);
            end else begin
                r_hi <= mid;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sktt_read_mux.sv
// Two-stage registered selection of one cell entry by index.
// Depends on sktt_pkg.
`default_nettype none

module sktt_read_mux (
    input  wire logic                       i_clk,
    input  wire logic [sktt_pkg::IDX_W-1:0] i_sel,
    input  wire sktt_pkg::t_entry           i_entries [sktt_pkg::TABLE_DEPTH],
    output sktt_pkg::t_entry                o_entry
);
    import sktt_pkg::*;

    logic [RD_SEL_W-1:0] sel_ext;
    t_entry              pad   [RD_NGRP*RD_GRP];
    t_entry              n_grp [RD_NGRP];
    t_entry              r_grp [RD_NGRP];
    t_entry              n_out;
    t_entry              r_out;

    assign sel_ext = RD_SEL_W'(i_sel);
    assign o_entry = r_out;

    for (genvar p = 0; p < RD_NGRP * RD_GRP; p++) begin : g_pad
        if (p < TABLE_DEPTH) begin : g_real
            assign pad[p] = i_entries[p];
        end else begin : g_fill
            assign pad[p] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < RD_NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < RD_GRP; j++) begin
                if (sel_ext[RD_GRP_W-1:0] == RD_GRP_W'(j)) begin
                    n_grp[g] = pad[g*RD_GRP + j];
                end
            end
        end
    end

    always_comb begin
        n_out = '0;
        for (int g = 0; g < RD_NGRP; g++) begin
            if (sel_ext[RD_SEL_W-1:RD_GRP_W] == RD_NGRP_W'(g)) begin
                n_out = r_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

### hw/rtl/sorted_key_table_with_tombstones.sv
// Top level of the sorted key table with deleted marks: control sequencer and cell row.
// Depends on sktt_pkg, sktt_cell, sktt_search and sktt_read_mux.
//
// Usage. A command word (i_cmd, i_key, i_payload, i_index) is taken at the rising edge
// at which start is high and busy is low. Exactly one result word follows: it sits on
// the o_ result ports, flagged by o_strobe for a single cycle, and o_entry_count gives
// the number of entries held after the command. The receiver cannot stall, so the
// result is simply presented, and the ports hold it until the next result word.
// After the accepting edge each command passes these steps before its result cycle:
//   insert and remove: a compare state, then the lower-bound search, which halves the
//     range that it still has to cover at each step, then the finish;
//   read: the two registered stages of the read multiplexer, then the finish state;
//   trim: one odd/even swap round between neighbouring cells per entry held, then the
//     finish state;
//   insert into a full table and remove with key zero: straight to the finish state.
// busy falls in the cycle that shows the result, so a new word may be accepted then,
// and the block takes no new word before it has shown the result of the last one.
// Reset is synchronous and active low; it empties the table (fill count zero) and the
// entry storage is left as it is, since nothing at or above the fill count is ever read.
`default_nettype none

module sorted_key_table_with_tombstones (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [sktt_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [sktt_pkg::KEY_W-1:0]    i_key,
    input  wire logic [sktt_pkg::PAYLOAD_W-1:0] i_payload,
    input  wire logic [sktt_pkg::INDEX_W-1:0]  i_index,
    output logic                               o_strobe,
    output logic [sktt_pkg::STATUS_W-1:0]      o_status,
    output logic [sktt_pkg::POS_W-1:0]         o_position,
    output logic [sktt_pkg::KEY_W-1:0]         o_key_out,
    output logic [sktt_pkg::PAYLOAD_W-1:0]     o_payload_out,
    output logic                               o_deleted_out,
    output logic [sktt_pkg::COUNT_W-1:0]       o_entry_count
);
    import sktt_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP  = 7'b0000010,
        S_SRCH = 7'b0000100,
        S_TRIM = 7'b0001000,
        S_RD1  = 7'b0010000,
        S_RD2  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Latched command word.
    t_cmd                    r_cmd;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [INDEX_W-1:0]      r_index;

    // Fill count, and how many held entries carry a deleted mark.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_marked;
    logic [CNT_W-1:0] r_round;

    // Result registers.
    logic                 r_strobe;
    t_status              r_status;
    logic [POS_W-1:0]     r_position;
    logic [KEY_W-1:0]     r_key_out;
    logic [PAYLOAD_W-1:0] r_payload_out;
    logic                 r_deleted_out;

    // Cell row.
    t_cell_ctl              cell_ctl;
    t_entry                 new_entry;
    t_entry                 cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] live_vec;
    logic [TABLE_DEPTH-1:0] mark_vec;

    // Search and read units.
    logic             srch_load;
    logic             srch_done;
    logic [CNT_W-1:0] srch_pos;
    logic [IDX_W-1:0] srch_idx;
    t_entry           rd_entry;

    logic full;
    logic key_zero;
    logic found;
    logic in_range;
    logic accept;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign key_zero = (r_key == '0);
    assign srch_idx = srch_pos[IDX_W-1:0];
    // The lower bound is the first cell that can hold a remove hit, so its flag decides.
    assign found    = (srch_pos < r_count) && eq_vec[srch_idx];
    assign in_range = int'(r_index) < int'(r_count);

    assign new_entry.key     = r_key;
    assign new_entry.payload = r_payload;
    assign new_entry.mark    = 1'b0;

    // The row of cells. Cell zero sees a neighbour below that is always "key below"
    // and live, so it is the insertion point whenever its own key is not below, and it
    // never takes part as the upper half of a swap. The top cell has no live neighbour
    // above.
    for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
        t_entry below_e;
        t_entry above_e;
        logic   below_lt;
        logic   below_live;
        logic   above_live;

        if (c == 0) begin : g_first
            assign below_e    = '0;
            assign below_lt   = 1'b1;
            assign below_live = 1'b1;
        end else begin : g_mid_lo
            assign below_e    = cell_entry[c-1];
            assign below_lt   = lt_vec[c-1];
            assign below_live = live_vec[c-1];
        end

        if (c == TABLE_DEPTH - 1) begin : g_last
            assign above_e    = '0;
            assign above_live = 1'b0;
        end else begin : g_mid_hi
            assign above_e    = cell_entry[c+1];
            assign above_live = live_vec[c+1];
        end

        sktt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_new        (new_entry),
            .i_count      (r_count),
            .i_pos        (IDX_W'(c)),
            .i_below      (below_e),
            .i_below_lt   (below_lt),
            .i_below_live (below_live),
            .i_above      (above_e),
            .i_above_live (above_live),
            .o_entry      (cell_entry[c]),
            .o_lt         (lt_vec[c]),
            .o_eq         (eq_vec[c]),
            .o_live       (live_vec[c])
        );

        assign mark_vec[c] = cell_entry[c].mark;
    end

    sktt_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (srch_load),
        .i_count (r_count),
        .i_lt    (lt_vec),
        .o_done  (srch_done),
        .o_pos   (srch_pos)
    );

    sktt_read_mux u_read_mux (
        .i_clk     (i_clk),
        .i_sel     (IDX_W'(r_index)),
        .i_entries (cell_entry),
        .o_entry   (rd_entry)
    );

    // Next state. Insert into a full table and remove with key zero go straight to the finish.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_INSERT: n_state = full ? S_FIN : S_CMP;
                        CMD_REMOVE: n_state = (KEY_BITS'(i_key) == '0) ? S_FIN : S_CMP;
                        CMD_TRIM:   n_state = S_TRIM;
                        default:    n_state = S_RD1;
                    endcase
                end
            end
            S_CMP:   n_state = S_SRCH;
            S_SRCH:  n_state = srch_done ? S_FIN : S_SRCH;
            S_TRIM:  n_state = (r_round == r_count) ? S_FIN : S_TRIM;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Cell row operation for this cycle.
    always_comb begin
        cell_ctl.op    = OP_HOLD;
        cell_ctl.phase = r_round[0];
        srch_load      = (r_state == S_CMP);
        case (r_state)
            S_CMP: cell_ctl.op = OP_CAPTURE;
            S_TRIM: begin
                if (r_round != r_count) begin
                    cell_ctl.op = OP_SWAP;
                end
            end
            S_FIN: begin
                if (r_cmd == CMD_INSERT && !full) begin
                    cell_ctl.op = OP_INSERT;
                end else if (r_cmd == CMD_REMOVE && !key_zero) begin
                    cell_ctl.op = OP_MARK;
                end
            end
            default: cell_ctl.op = OP_HOLD;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_marked <= '0;
            r_round  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_FIN);
            if (r_state == S_IDLE) begin
                r_round <= '0;
            end else if (r_state == S_TRIM && r_round != r_count) begin
                r_round <= r_round + CNT_W'(1);
            end
            if (r_state == S_FIN) begin
                case (r_cmd)
                    CMD_INSERT: begin
                        if (!full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        // An entry that is marked a second time is counted once.
                        if (!key_zero && found && !mark_vec[srch_idx]) begin
                            r_marked <= r_marked + CNT_W'(1);
                        end
                    end
                    CMD_TRIM: begin
                        r_count  <= r_count - r_marked;
                        r_marked <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Command word and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_key     <= KEY_BITS'(i_key);
            r_payload <= PAYLOAD_BITS'(i_payload);
            r_index   <= i_index;
        end
        if (r_state == S_FIN) begin
            r_status      <= ST_OK;
            r_position    <= '0;
            r_key_out     <= '0;
            r_payload_out <= '0;
            r_deleted_out <= 1'b0;
            case (r_cmd)
                CMD_INSERT: begin
                    if (full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_position <= POS_W'(srch_pos);
                    end
                end
                CMD_REMOVE: begin
                    if (key_zero) begin
                        r_status <= ST_BAD_KEY;
                    end else if (found) begin
                        r_position <= POS_W'(srch_pos);
                    end else begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                CMD_TRIM: begin
                end
                default: begin
                    if (!in_range) begin
                        r_status <= ST_RANGE;
                    end else begin
                        r_position    <= POS_W'(r_index);
                        r_key_out     <= KEY_W'(rd_entry.key);
                        r_payload_out <= PAYLOAD_W'(rd_entry.payload);
                        r_deleted_out <= rd_entry.mark;
                    end
                end
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_payload_out;
    assign o_deleted_out = r_deleted_out;
    assign o_entry_count = COUNT_W'(r_count);

    // A result word only ever follows the finishing cycle of the sequencer.
    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_FIN))
        else $error("result strobe without a finished command");

    // The fill count never exceeds the table and marked entries are among those held.
    a_count_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(TABLE_DEPTH)) && (r_marked <= r_count))
        else $error("fill count or marked count out of bounds");

    // A newly accepted word cannot produce its result in the very next cycle.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_strobe)
        else $error("result strobe right after acceptance");

    // Trim ends with its round counter equal to the fill count it started from.
    a_trim_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM && n_state == S_FIN) |-> (r_round == r_count))
        else $error("trim left before all swap rounds were run");

endmodule

`default_nettype wire

### tb/sktt_checker.sv
// Scoreboard for the sorted key table: keeps its own copy of the table, predicts each result word
// and compares it with what the block presents. Depends on sktt_pkg only.
module sktt_checker
    import sktt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [KEY_W-1:0]     i_key,
    input  wire logic [PAYLOAD_W-1:0] i_payload,
    input  wire logic [INDEX_W-1:0]   i_index,
    input  wire logic                 i_strobe,
    input  wire logic [STATUS_W-1:0]  i_status,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic [KEY_W-1:0]     i_key_out,
    input  wire logic [PAYLOAD_W-1:0] i_payload_out,
    input  wire logic                 i_deleted_out,
    input  wire logic [COUNT_W-1:0]   i_entry_count,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status                status;
        logic [POS_W-1:0]       position;
        logic [KEY_W-1:0]       key;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   deleted;
        logic [COUNT_W-1:0]     count;
    } t_answer;

    logic [KEY_W-1:0]     row_key     [TABLE_DEPTH];
    logic [PAYLOAD_W-1:0] row_payload [TABLE_DEPTH];
    logic                 row_mark    [TABLE_DEPTH];
    int unsigned          fill;
    t_answer              answers_due [$];
    int                   fails = 0;

    assign o_fail_count = fails;

    // Lowest position whose key is not below k; marked entries count like any others.
    function automatic int unsigned first_not_below(logic [KEY_W-1:0] k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = fill;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (row_key[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // Applies one command word to the table copy and returns the answer it should give.
    function automatic t_answer apply_word(t_cmd cmd, logic [KEY_W-1:0] key,
                                           logic [PAYLOAD_W-1:0] payload,
                                           logic [INDEX_W-1:0] idx);
        t_answer     a;
        int unsigned at;
        int unsigned w;
        a = '0;
        a.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (fill >= TABLE_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    at = first_not_below(key);
                    for (int j = fill; j > at; j--) begin
                        row_key[j]     = row_key[j-1];
                        row_payload[j] = row_payload[j-1];
                        row_mark[j]    = row_mark[j-1];
                    end
                    row_key[at]     = key;
                    row_payload[at] = payload;
                    row_mark[at]    = 1'b0;
                    fill++;
                    a.position = at[POS_W-1:0];
                end
            end
            CMD_REMOVE: begin
                if (key == '0) begin
                    a.status = ST_BAD_KEY;
                end else begin
                    at = first_not_below(key);
                    if (at < fill && row_key[at] == key) begin
                        row_mark[at] = 1'b1;
                        a.position   = at[POS_W-1:0];
                    end else begin
                        a.status = ST_NOT_FOUND;
                    end
                end
            end
            CMD_TRIM: begin
                w = 0;
                for (int unsigned r = 0; r < fill; r++) begin
                    if (!row_mark[r]) begin
                        row_key[w]     = row_key[r];
                        row_payload[w] = row_payload[r];
                        row_mark[w]    = 1'b0;
                        w++;
                    end
                end
                fill = w;
            end
            default: begin
                if (idx >= fill) begin
                    a.status = ST_RANGE;
                end else begin
                    a.position = idx;
                    a.key      = row_key[idx];
                    a.payload  = row_payload[idx];
                    a.deleted  = row_mark[idx];
                end
            end
        endcase
        a.count = fill[COUNT_W-1:0];
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        fails++;
        if (fails <= 100)
            $display("sktt_checker: %0t ns: %s: got %h, want %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            answers_due.delete();
            fill = 0;
        end else begin
            // Results first: a new word may be taken at the edge that ends a result cycle.
            if (i_strobe) begin
                got.status   = t_status'(i_status);
                got.position = i_position;
                got.key      = i_key_out;
                got.payload  = i_payload_out;
                got.deleted  = i_deleted_out;
                got.count    = i_entry_count;
                if (answers_due.size() == 0) begin
                    report_mismatch("result word with no command outstanding", '0, '0);
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.position !== want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.key !== want.key)
                        report_mismatch("key_out", got.key, want.key);
                    if (got.payload !== want.payload)
                        report_mismatch("payload_out", got.payload, want.payload);
                    if (got.deleted !== want.deleted)
                        report_mismatch("deleted_out", got.deleted, want.deleted);
                    if (got.count !== want.count)
                        report_mismatch("entry_count", got.count, want.count);
                end
            end
            if (i_start && !i_busy)
                answers_due.push_back(apply_word(t_cmd'(i_cmd), i_key, i_payload, i_index));
        end
        o_pending <= answers_due.size();
        o_fill    <= fill;
    end

endmodule

### tb/tb.sv
// Top of the testbench for the sorted key table: clock, reset, command stimulus and verdict.
// Depends on sktt_pkg, the block sorted_key_table_with_tombstones and sktt_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sktt_pkg::*;

    // Longest quiet spell that a correct run can show is a trim of a full table plus a sender
    // gap; the limit leaves ample margin above that.
    localparam int QUIET_LIMIT = 3000;
    localparam int WORD_TARGET = 1900;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [KEY_W-1:0]     i_key = '0;
    logic [PAYLOAD_W-1:0] i_payload = '0;
    logic [INDEX_W-1:0]   i_index = '0;
    logic                 o_strobe;
    logic [STATUS_W-1:0]  o_status;
    logic [POS_W-1:0]     o_position;
    logic [KEY_W-1:0]     o_key_out;
    logic [PAYLOAD_W-1:0] o_payload_out;
    logic                 o_deleted_out;
    logic [COUNT_W-1:0]   o_entry_count;

    int chk_fails;
    int chk_pending;
    int chk_fill;

    // Bookkeeping for the sender and the summary.
    bit start_hi = 1'b0;
    int burst_left = 1;
    int words_sent = 0;
    int sent_by_cmd [4];
    int capacity_hits = 0;
    int quiet = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sorted_key_table_with_tombstones u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_index       (i_index),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_deleted_out (o_deleted_out),
        .o_entry_count (o_entry_count)
    );

    sktt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_index       (i_index),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_position    (o_position),
        .i_key_out     (o_key_out),
        .i_payload_out (o_payload_out),
        .i_deleted_out (o_deleted_out),
        .i_entry_count (o_entry_count),
        .o_fail_count  (chk_fails),
        .o_pending     (chk_pending),
        .o_fill        (chk_fill)
    );

    // Watchdog: any cycle in which neither a command word nor a result word moves counts as
    // quiet. A hung block, or a result that never turns up, trips it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Drives one command word and returns at the falling edge after it has been taken.
    // busy only moves at a rising edge, so its value at a falling edge tells whether the
    // next rising edge accepts the word. After most bursts the sender idles for a while,
    // scrambling the fields so that the block must ignore them whilst start is low.
    task automatic issue_word(t_cmd cmd, logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] payload,
                              logic [INDEX_W-1:0] idx);
        int gap;
        start     <= 1'b1;
        start_hi   = 1'b1;
        i_cmd     <= cmd;
        i_key     <= key;
        i_payload <= payload;
        i_index   <= idx;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        sent_by_cmd[cmd]++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // Roughly a quarter of the bursts run straight on into the next one.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start     <= 1'b0;
                start_hi   = 1'b0;
                i_cmd     <= CMD_W'($urandom_range(0, 3));
                i_key     <= $urandom();
                i_payload <= $urandom();
                i_index   <= INDEX_W'($urandom_range(0, 255));
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Holds the sender back until the block has answered every word it has taken.
    task automatic drain_results();
        if (start_hi) begin
            start   <= 1'b0;
            start_hi = 1'b0;
        end
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    // Keys come mostly from a small pool so that equal keys pile up and removes hit; the
    // rest are zero, the all-ones key or anything at all.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68) return $urandom_range(1, 40);
        if (r < 78) return '0;
        if (r < 85) return '1;
        return $urandom();
    endfunction

    // Read positions: mostly inside the table, some exactly at its end, some anywhere.
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && chk_fill > 0) return INDEX_W'($urandom_range(0, chk_fill - 1));
        if (r < 6 && chk_fill < 256) return INDEX_W'(chk_fill);
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    // Any index at all, for commands that ignore it.
    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    task automatic random_word();
        int r;
        int ins_weight;
        r = $urandom_range(0, 99);
        // Ease off inserts once the table is well filled so that it does not sit at capacity.
        ins_weight = (chk_fill > 160) ? 20 : 40;
        if (r < ins_weight)
            issue_word(CMD_INSERT, pick_key(), $urandom(), any_index());
        else if (r < ins_weight + 25)
            issue_word(CMD_REMOVE, pick_key(), $urandom(), any_index());
        else if (r < ins_weight + 30)
            issue_word(CMD_TRIM, $urandom(), $urandom(), any_index());
        else
            issue_word(CMD_READ, $urandom(), $urandom(), pick_index());
    endtask

    // Fills the table to capacity, pushes further inserts against the full table, reads
    // across the whole index range (the top position included), marks a batch and trims.
    task automatic fill_to_capacity();
        while (chk_fill < TABLE_DEPTH) begin
            if ($urandom_range(0, 5) == 0)
                issue_word(CMD_READ, $urandom(), $urandom(), pick_index());
            else
                issue_word(CMD_INSERT, pick_key(), $urandom(), any_index());
        end
        capacity_hits++;
        repeat (8) issue_word(CMD_INSERT, pick_key(), $urandom(), any_index());
        issue_word(CMD_READ, $urandom(), $urandom(), 8'hFF);
        repeat (24) issue_word(CMD_READ, $urandom(), $urandom(), any_index());
        repeat (16) issue_word(CMD_REMOVE, pick_key(), $urandom(), any_index());
        issue_word(CMD_TRIM, $urandom(), $urandom(), any_index());
        drain_results();
    endtask

    initial begin
        int next_fill;
        int next_drain;
        foreach (sent_by_cmd[c]) sent_by_cmd[c] = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: empty table corners first, then extreme keys and payloads,
        // equal keys, a repeated mark, misses around stored keys, and a trim.
        issue_word(CMD_READ,   '0, '0, 8'h00);                   // read on an empty table
        issue_word(CMD_REMOVE, '0, '0, 8'h00);                   // key zero is refused
        issue_word(CMD_REMOVE, 32'd5, '0, 8'h00);                // nothing there to mark
        issue_word(CMD_TRIM,   '0, '0, 8'h00);                   // trim of an empty table
        issue_word(CMD_INSERT, '0, '0, 8'h00);                   // smallest key and payload
        issue_word(CMD_INSERT, '1, '1, 8'hFF);                   // largest key and payload
        issue_word(CMD_INSERT, 32'd5, 32'hA5A5_A5A5, 8'h00);
        issue_word(CMD_INSERT, 32'd5, 32'h5A5A_5A5A, 8'h00);     // goes before the equal key
        issue_word(CMD_INSERT, 32'd3, 32'h0000_0001, 8'h00);
        issue_word(CMD_REMOVE, 32'd5, '0, 8'h00);                // marks the lower of the pair
        issue_word(CMD_REMOVE, 32'd5, '0, 8'h00);                // same entry, still marked
        issue_word(CMD_REMOVE, 32'd4, '0, 8'h00);                // miss between stored keys
        issue_word(CMD_REMOVE, '1, '0, 8'h00);                   // top end of the key range
        issue_word(CMD_REMOVE, '0, '0, 8'h00);                   // key zero, though stored
        issue_word(CMD_READ,   '0, '0, 8'h02);
        issue_word(CMD_READ,   '0, '0, 8'h03);
        issue_word(CMD_READ,   '0, '0, 8'h05);                   // exactly at the end
        issue_word(CMD_READ,   '0, '0, 8'hFF);                   // far past the end
        issue_word(CMD_TRIM,   '0, '0, 8'h00);
        issue_word(CMD_READ,   '0, '0, 8'h00);
        issue_word(CMD_READ,   '0, '0, 8'h02);
        drain_results();

        // Random part, with two excursions to a full table and a pause now and then until
        // every result has come back.
        next_fill  = 600;
        next_drain = 150;
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= next_fill) begin
                fill_to_capacity();
                next_fill += 700;
            end else begin
                random_word();
            end
            if (words_sent >= next_drain) begin
                drain_results();
                next_drain += 150;
            end
        end

        // Wind down: wait for the last answers, then a little longer so that a stray
        // result word would still be caught.
        drain_results();
        repeat (20) @(negedge i_clk);

        $display("tb: %0d words sent: %0d insert, %0d remove, %0d trim, %0d read",
                 words_sent, sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_REMOVE],
                 sent_by_cmd[CMD_TRIM], sent_by_cmd[CMD_READ]);
        $display("tb: table filled to capacity %0d times, %0d mismatches seen",
                 capacity_hits, chk_fails);
        if (chk_fails == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/sktt_pkg.sv
hw/rtl/sktt_cell.sv
hw/rtl/sktt_search.sv
hw/rtl/sktt_read_mux.sv
hw/rtl/sorted_key_table_with_tombstones.sv
tb/sktt_checker.sv
tb/tb.sv
